/* rtl/core/xoo_pkg.sv */
// Shared types, round count and round-constant table for the Xoodoo permutation unit.
package xoo_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned WORD_COUNT  = 12;
    localparam int unsigned LANE_COUNT  = 4;
    localparam int unsigned RC_W        = 10;
    localparam int unsigned TABLE_DEPTH = 12;

    // Number of rounds, 1..12; the last ROUND_COUNT table entries are used.
    localparam int unsigned ROUND_COUNT = 12;
    localparam int unsigned FIRST_ROUND = TABLE_DEPTH - ROUND_COUNT;

    typedef logic [WORD_W-1:0]                 t_word;
    typedef logic [WORD_COUNT-1:0][WORD_W-1:0] t_state;
    typedef logic [RC_W-1:0]                   t_rc;

    localparam t_rc RC_TABLE [TABLE_DEPTH] = '{
        10'h058, 10'h038, 10'h3c0, 10'h0d0, 10'h120, 10'h014,
        10'h060, 10'h02c, 10'h380, 10'h0f0, 10'h1a0, 10'h012
    };

    // Constant for pipeline round idx (0 is the first round applied).
    function automatic t_rc xoo_rc(input int unsigned idx);
        logic [3:0] slot;
        slot = 4'(FIRST_ROUND + idx);
        return RC_TABLE[slot];
    endfunction

endpackage

/* rtl/core/xoodoo_permutation_unit.sv */
// Top level of the pipelined Xoodoo permutation unit.
//
// Usage:
//   Present a 384-bit state on i_word_0..i_word_11 (word 4*y+x is plane y,
//   lane x) and raise start. A word is taken at each rising edge where start
//   is high and busy is low. busy is high while i_rst_n is low and in the
//   first cycle out of reset; after that it stays low, so a new word can
//   enter every cycle. Each of the ROUND_COUNT rounds has its own register
//   stage; a state taken at an edge passes through all of them and shows
//   on o_out_word_* with o_valid high.
//   Throughput: one word per cycle; every stage advances on every clock.
//   Each result is on the outputs for exactly one cycle, marked by o_valid.
//   The receiver cannot stall, so it must capture the word in that cycle.
//   Reset (i_rst_n low, synchronous) drops every word in flight: all stage
//   valid bits clear and no result appears for the words that were lost.
//   No state is kept between words.
module xoodoo_permutation_unit import xoo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_word_0,
    input  logic [31:0] i_word_1,
    input  logic [31:0] i_word_2,
    input  logic [31:0] i_word_3,
    input  logic [31:0] i_word_4,
    input  logic [31:0] i_word_5,
    input  logic [31:0] i_word_6,
    input  logic [31:0] i_word_7,
    input  logic [31:0] i_word_8,
    input  logic [31:0] i_word_9,
    input  logic [31:0] i_word_10,
    input  logic [31:0] i_word_11,
    output logic        o_valid,
    output logic [31:0] o_out_word_0,
    output logic [31:0] o_out_word_1,
    output logic [31:0] o_out_word_2,
    output logic [31:0] o_out_word_3,
    output logic [31:0] o_out_word_4,
    output logic [31:0] o_out_word_5,
    output logic [31:0] o_out_word_6,
    output logic [31:0] o_out_word_7,
    output logic [31:0] o_out_word_8,
    output logic [31:0] o_out_word_9,
    output logic [31:0] o_out_word_10,
    output logic [31:0] o_out_word_11
);

    logic   r_busy;
    logic   accept;
    logic   stage_valid [ROUND_COUNT+1];
    t_state stage_state [ROUND_COUNT+1];
    t_state result;

    // Hold busy through the first cycle after reset, then drop it for good.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    // Stage 0 is the input word itself; round 0 works straight off the ports.
    assign stage_valid[0] = accept;
    assign stage_state[0] = {i_word_11, i_word_10, i_word_9, i_word_8,
                             i_word_7,  i_word_6,  i_word_5, i_word_4,
                             i_word_3,  i_word_2,  i_word_1, i_word_0};

    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        xoo_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stage_valid[g]),
            .i_state (stage_state[g]),
            .i_rc    (xoo_rc(g)),
            .o_valid (stage_valid[g+1]),
            .o_state (stage_state[g+1])
        );
    end

    // The last round's register is the output register.
    assign result        = stage_state[ROUND_COUNT];
    assign o_valid       = stage_valid[ROUND_COUNT];
    assign o_out_word_0  = result[0];
    assign o_out_word_1  = result[1];
    assign o_out_word_2  = result[2];
    assign o_out_word_3  = result[3];
    assign o_out_word_4  = result[4];
    assign o_out_word_5  = result[5];
    assign o_out_word_6  = result[6];
    assign o_out_word_7  = result[7];
    assign o_out_word_8  = result[8];
    assign o_out_word_9  = result[9];
    assign o_out_word_10 = result[10];
    assign o_out_word_11 = result[11];

    // Every accepted word comes out with o_valid after all ROUND_COUNT rounds.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##ROUND_COUNT o_valid)
        else $error("accepted word did not emerge after ROUND_COUNT cycles");

    // No result appears that was not accepted and passed through every round.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, ROUND_COUNT))
        else $error("result without a matching accepted word");

    // Reset flushes the pipeline and busy releases right after it.
    a_reset_flush: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> (!o_valid && busy))
        else $error("pipeline not flushed by reset");

    a_busy_release: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n)) |-> !busy)
        else $error("busy high outside the reset window");

endmodule

/* rtl/core/xoo_round.sv */
// One Xoodoo round followed by a pipeline register with its valid bit.
module xoo_round import xoo_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_state i_state,
    input  t_rc    i_rc,
    output logic   o_valid,
    output t_state o_state
);

    logic   r_valid;
    t_state r_state;
    t_state n_state;

    function automatic t_word rotl(input t_word v, input logic [4:0] n);
        return (v << n) | (v >> (6'd32 - {1'b0, n}));
    endfunction

    always_comb begin
        t_word      p [LANE_COUNT];
        t_word      e [LANE_COUNT];
        t_word      a [WORD_COUNT];
        t_word      b [WORD_COUNT];
        t_word      c0;
        t_word      c1;
        t_word      c2;
        logic [1:0] prev;
        logic [1:0] dest;

        // theta: column parity folded in from the western neighbor
        for (int x = 0; x < LANE_COUNT; x++) begin
            p[x] = i_state[x] ^ i_state[x + 4] ^ i_state[x + 8];
        end
        for (int x = 0; x < LANE_COUNT; x++) begin
            prev = 2'(x + 3);
            e[x] = rotl(p[prev], 5'd5) ^ rotl(p[prev], 5'd14);
        end
        for (int i = 0; i < WORD_COUNT; i++) begin
            a[i] = i_state[i] ^ e[i % LANE_COUNT];
        end

        // rho-west
        for (int x = 0; x < LANE_COUNT; x++) begin
            prev      = 2'(x + 3);
            b[x]      = a[x];
            b[x + 4]  = a[4 + prev];
            b[x + 8]  = rotl(a[x + 8], 5'd11);
        end

        // iota
        b[0] = b[0] ^ {{(WORD_W-RC_W){1'b0}}, i_rc};

        // chi, then rho-east
        n_state = '0;
        for (int x = 0; x < LANE_COUNT; x++) begin
            c0   = b[x];
            c1   = b[x + 4];
            c2   = b[x + 8];
            dest = 2'(x + 2);
            n_state[x]        = c0 ^ (~c1 & c2);
            n_state[x + 4]    = rotl(c1 ^ (~c2 & c0), 5'd1);
            n_state[8 + dest] = rotl(c2 ^ (~c0 & c1), 5'd8);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule
